// ===== src/frb_pkg.sv =====
`timescale 1ns / 1ps

package frb_pkg;

  // Message buffer size in bytes.
  localparam int CAPACITY = 512;
  localparam int ADDR_W   = $clog2(CAPACITY);

  // Field widths of the item formats.
  localparam int KIND_W = 2;
  localparam int POS_W  = 10;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 10;

  // Width of the generation tag held per byte in the coverage memory.
  localparam int EPOCH_W = 8;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] data;
    logic              has_data;
    logic              more;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              complete;
    logic [POS_W-1:0]  message_length;
    logic              overflow;
  } out_item_t;

  // Requests from the item pipeline to the coverage tracker.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              set_en;
    logic [ADDR_W-1:0] set_addr;
    logic              clear;
  } cov_req_t;

  // Status returned by the coverage tracker.
  typedef struct packed {
    logic covered;
    logic busy;
    logic wrap;
  } cov_sts_t;

endpackage

// ===== src/frb_ram.sv =====
`timescale 1ns / 1ps

module frb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read returns the old contents when the same address is written in that cycle.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/frb_cover.sv =====
`timescale 1ns / 1ps

module frb_cover import frb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cov_req_t req,
  output cov_sts_t sts
);

  // A byte counts as covered when its stored tag equals the current generation.
  // Clearing the message only advances the generation; when the tag space runs
  // out, every tag is swept back to zero and the generation restarts at one.

  logic [EPOCH_W-1:0] epoch_r;
  logic               busy_r;
  logic [ADDR_W-1:0]  sweep_addr_r;
  logic               fwd_v_r;
  logic [ADDR_W-1:0]  fwd_addr_r;
  logic [ADDR_W-1:0]  rd_addr_r;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [EPOCH_W-1:0] ram_wdata;
  logic [EPOCH_W-1:0] ram_rdata;

  assign ram_we    = busy_r | req.set_en;
  assign ram_waddr = busy_r ? sweep_addr_r : req.set_addr;
  assign ram_wdata = busy_r ? '0 : epoch_r;

  frb_ram #(
    .WIDTH(EPOCH_W),
    .DEPTH(CAPACITY)
  ) u_tag_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (req.rd_en),
    .raddr(req.rd_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_addr_r <= req.rd_addr;
    end
    if (req.set_en) begin
      fwd_addr_r <= req.set_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r      <= EPOCH_W'(1);
      busy_r       <= 1'b1;
      sweep_addr_r <= '0;
      fwd_v_r      <= 1'b0;
    end else begin
      if (busy_r) begin
        if (sweep_addr_r == ADDR_W'(CAPACITY - 1)) begin
          busy_r <= 1'b0;
        end
        sweep_addr_r <= sweep_addr_r + ADDR_W'(1);
      end
      if (req.clear) begin
        fwd_v_r <= 1'b0;
        if (epoch_r == '1) begin
          epoch_r      <= EPOCH_W'(1);
          busy_r       <= 1'b1;
          sweep_addr_r <= '0;
        end else begin
          epoch_r <= epoch_r + EPOCH_W'(1);
        end
      end else if (req.set_en) begin
        fwd_v_r <= 1'b1;
      end
    end
  end

  // The last tag write may have landed on the same edge as this read.
  assign sts.covered = (ram_rdata == epoch_r) || (fwd_v_r && (fwd_addr_r == rd_addr_r));
  assign sts.busy    = busy_r;
  assign sts.wrap    = (epoch_r == '1);

endmodule

// ===== src/fragment_reassembly_buffer.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall    in_item  (kind, position, data, has_data, more)
// out_      output     out_valid / out_stall  out_item (read_data, complete, length, overflow)
//
// One item is taken per cycle while in_stall is low; its result passes through the item
// register into the output register. The pace is set by the single read-modify-write of
// the byte and tag memories. After reset the tag memory is swept with in_stall held high.
// Every 255th clear item restarts the tag generations, costing one further sweep.
// A held result stalls the item in flight, which in turn stalls the input.

module fragment_reassembly_buffer import frb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // Item register: the item whose memory reads are under way.
  logic      s1_valid_r;
  in_item_t  s1_r;

  // Message status.
  logic [POS_W-1:0] len_r;
  logic [POS_W-1:0] len_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             last_r;
  logic             last_nxt;

  // Result register.
  logic      out_valid_r;
  out_item_t out_r;
  out_item_t out_nxt;

  // Most recent byte write, for a read that overlapped it in the memory.
  logic              bfwd_v_r;
  logic [ADDR_W-1:0] bfwd_addr_r;
  logic [DATA_W-1:0] bfwd_data_r;

  logic              accept;
  logic              s1_fire;
  logic [ADDR_W-1:0] s1_addr;
  logic              byte_in_range;
  logic              end_in_range;
  logic              byte_we;
  logic [DATA_W-1:0] byte_rdata;
  logic [DATA_W-1:0] rd;
  logic              ovf;
  logic              cov_set;
  logic              do_clear;
  logic [POS_W-1:0]  end_pos;
  cov_req_t          cov_req;
  cov_sts_t          cov_sts;

  // The item register moves on whenever the result register is free or being emptied.
  assign s1_fire = s1_valid_r && (!out_valid_r || !out_stall);

  // No intake while sweeping, while the item cannot move, or when a clear that
  // restarts the tag generations is about to leave (the sweep must come first).
  assign in_stall = cov_sts.busy || (s1_valid_r && !s1_fire) ||
                    (s1_valid_r && (s1_r.kind == KIND_CLEAR) && cov_sts.wrap);
  assign accept   = in_valid && !in_stall;

  assign s1_addr       = ADDR_W'(s1_r.position);
  assign byte_in_range = int'(s1_r.position) < CAPACITY;
  assign end_in_range  = int'(s1_r.position) <= CAPACITY;
  assign end_pos       = s1_r.position + POS_W'(1);

  always_comb begin
    len_nxt  = len_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    rd       = '0;
    ovf      = 1'b0;
    byte_we  = 1'b0;
    cov_set  = 1'b0;
    do_clear = 1'b0;
    unique case (s1_r.kind)
      KIND_WRITE: begin
        if (s1_r.has_data) begin
          if (!byte_in_range) begin
            ovf = 1'b1;
          end else begin
            byte_we = 1'b1;
            cov_set = 1'b1;
            if (!cov_sts.covered) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
            if (end_pos > len_r) begin
              len_nxt = end_pos;
            end
            if (!s1_r.more) begin
              last_nxt = 1'b1;
            end
          end
        end else begin
          // An empty fragment only pushes the length out to its offset and marks the last one.
          if (!end_in_range) begin
            ovf = 1'b1;
          end else begin
            if (s1_r.position > len_r) begin
              len_nxt = s1_r.position;
            end
            if (!s1_r.more) begin
              last_nxt = 1'b1;
            end
          end
        end
      end
      KIND_READ: begin
        if (byte_in_range) begin
          rd = (bfwd_v_r && (bfwd_addr_r == s1_addr)) ? bfwd_data_r : byte_rdata;
        end
      end
      KIND_CLEAR: begin
        do_clear = 1'b1;
        len_nxt  = '0;
        cnt_nxt  = '0;
        last_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_nxt.read_data      = rd;
    out_nxt.complete       = last_nxt && (cnt_nxt == CNT_W'(len_nxt));
    out_nxt.message_length = len_nxt;
    out_nxt.overflow       = ovf;
  end

  assign cov_req.rd_en    = accept;
  assign cov_req.rd_addr  = ADDR_W'(in_item.position);
  assign cov_req.set_en   = s1_fire && cov_set;
  assign cov_req.set_addr = s1_addr;
  assign cov_req.clear    = s1_fire && do_clear;

  frb_cover u_cover (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (cov_req),
    .sts  (cov_sts)
  );

  frb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_byte_ram (
    .clk  (clk),
    .we   (s1_fire && byte_we),
    .waddr(s1_addr),
    .wdata(s1_r.data),
    .re   (accept),
    .raddr(ADDR_W'(in_item.position)),
    .rdata(byte_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      len_r       <= '0;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      bfwd_v_r    <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        len_r       <= len_nxt;
        cnt_r       <= cnt_nxt;
        last_r      <= last_nxt;
        if (byte_we) begin
          bfwd_v_r <= 1'b1;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_item;
    end
    if (s1_fire) begin
      out_r <= out_nxt;
      if (byte_we) begin
        bfwd_addr_r <= s1_addr;
        bfwd_data_r <= s1_r.data;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
